[rtl/core/rpr_pkg.sv]
// Shared constants, types and helper functions of the polyphase rational resampler.
package rpr_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 18;
    localparam int CIDX_W          = 8;
    localparam int ACTION_W        = 2;
    localparam int FACTOR_W        = 4;
    localparam int TAPS_W          = 9;
    localparam int RES_W           = 4;
    localparam int KCNT_W          = 8;
    localparam int IDX_W           = 12;
    localparam int PROD_W          = SAMPLE_W + COEF_W;
    localparam int ACC_W           = 42;
    localparam int MAX_FACTOR      = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int FACTOR_CAP      = (MAX_FACTOR < MAX_RESULTS) ? MAX_FACTOR : MAX_RESULTS;
    localparam int MAX_BRANCH_TAPS = 256;
    localparam int DEF_FILTER_TAPS = 256;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 9;

    // Input item kinds carried on tuser
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT,
        ST_PASS
    } state_t;

    typedef struct packed {
        logic take;       // input transfer this cycle
        logic start;      // set up a new branch sum
        logic issue;      // issue one tap
        logic round;      // round and saturate the accumulator
        logic emit;       // load a filtered result into the output register
        logic emit_pass;  // load the pass-through sample into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_push;     // offered item is a sample push
        logic pass_mode;   // L = M = 1
        logic has_output;  // residue below L
        logic tap_last;    // the tap being issued is the last of the branch
        logic pipe_empty;  // no tap in flight
        logic last_phase;  // result being emitted ends this push
        logic out_free;    // output register can take a result
    } dp_status_t;

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
        logic [FACTOR_W-1:0] r;
        if (v == '0) begin
            r = FACTOR_W'(1);
        end else if (v > FACTOR_W'(FACTOR_CAP)) begin
            r = FACTOR_W'(FACTOR_CAP);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [TAPS_W-1:0] clamp_taps(input logic [TAPS_W-1:0] v);
        logic [TAPS_W-1:0] r;
        if (v == '0) begin
            r = TAPS_W'(1);
        end else if (v > TAPS_W'(MAX_BRANCH_TAPS)) begin
            r = TAPS_W'(MAX_BRANCH_TAPS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/core/rpr_ctrl.sv]
// Sequencing state machine of the polyphase rational resampler.
module rpr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  rpr_pkg::dp_status_t status,
    output rpr_pkg::ctrl_cmd_t  cmd
);
    import rpr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.take = 1'b1;
                    if (status.in_push) begin
                        if (status.pass_mode) begin
                            state_next = ST_PASS;
                        end else if (status.has_output) begin
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                if (status.tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_phase ? ST_IDLE : ST_START;
                end
            end
            ST_PASS: begin
                if (status.out_free) begin
                    cmd.emit_pass = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rpr_datapath.sv]
// Datapath: settings, residue, history and coefficient stores, MAC pipeline, output register.
module rpr_datapath #(
    parameter int FILTER_TAPS = rpr_pkg::DEF_FILTER_TAPS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [rpr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic [rpr_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rpr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    input  rpr_pkg::ctrl_cmd_t                 cmd,
    output rpr_pkg::dp_status_t                status
);
    import rpr_pkg::*;

    localparam int HA_W       = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int FW         = $clog2(FILTER_TAPS + 1);
    localparam int COEF_DEPTH = (FILTER_TAPS < MAX_BRANCH_TAPS) ? FILTER_TAPS : MAX_BRANCH_TAPS;
    localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int CMP_W      = (FW > KCNT_W) ? FW : KCNT_W;

    // Input fields
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [CIDX_W-1:0]   coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    assign sample_in  = s_axis_tdata[SAMPLE_W-1:0];
    assign coef_index = s_axis_tdata[SAMPLE_W +: CIDX_W];
    assign coef_value = s_axis_tdata[SAMPLE_W+CIDX_W +: COEF_W];

    // Settings
    logic [FACTOR_W-1:0] up_reg;
    logic [FACTOR_W-1:0] down_reg;
    logic [TAPS_W-1:0]   taps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= FACTOR_W'(1);
            down_reg <= FACTOR_W'(1);
            taps_reg <= TAPS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_UP:   up_reg   <= clamp_factor(cfg_data[FACTOR_W-1:0]);
                CFG_DOWN: down_reg <= clamp_factor(cfg_data[FACTOR_W-1:0]);
                CFG_TAPS: taps_reg <= clamp_taps(cfg_data[TAPS_W-1:0]);
                default:  ;
            endcase
        end
    end

    logic take_push;
    logic take_coef;
    logic take_clear;
    assign take_push  = cmd.take && (s_axis_tuser == ACT_PUSH);
    assign take_coef  = cmd.take && (s_axis_tuser == ACT_COEF);
    assign take_clear = cmd.take && (s_axis_tuser == ACT_CLEAR);

    // Phase residue
    logic [RES_W-1:0] res_reg;
    logic [RES_W:0]   res_sum;
    logic             pass_mode;
    logic             has_output;
    logic             last_phase;

    assign pass_mode  = (up_reg == FACTOR_W'(1)) && (down_reg == FACTOR_W'(1));
    assign has_output = res_reg < up_reg;
    assign res_sum    = {1'b0, res_reg} + {1'b0, down_reg};
    assign last_phase = res_sum >= {1'b0, up_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else if (take_clear) begin
            res_reg <= '0;
        end else if (take_push) begin
            if (pass_mode) begin
                res_reg <= '0;
            end else if (!has_output) begin
                res_reg <= res_reg - up_reg;
            end
        end else if (cmd.emit) begin
            res_reg <= last_phase ? RES_W'(res_sum - {1'b0, up_reg}) : RES_W'(res_sum);
        end
    end

    // History line: circular buffer, entries beyond the fill count read as zero
    logic signed [SAMPLE_W-1:0] hist_mem [FILTER_TAPS];
    logic [HA_W-1:0]            head_reg;
    logic [HA_W-1:0]            head_inc;
    logic [FW-1:0]              fill_reg;
    logic signed [SAMPLE_W-1:0] pass_reg;

    assign head_inc = (head_reg == HA_W'(FILTER_TAPS - 1)) ? '0 : head_reg + HA_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else if (take_clear) begin
            fill_reg <= '0;
        end else if (take_push) begin
            head_reg <= head_inc;
            if (fill_reg != FW'(FILTER_TAPS)) begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_push) begin
            hist_mem[head_inc] <= sample_in;
            pass_reg           <= sample_in;
        end
    end

    // Coefficient store with per-entry valid bits
    logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]    coef_vld_reg;
    logic                     coef_wr;

    assign coef_wr = take_coef && ({1'b0, coef_index} < (CIDX_W + 1)'(COEF_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
        end else if (coef_wr) begin
            coef_vld_reg[coef_index[CA_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_wr) begin
            coef_mem[coef_index[CA_W-1:0]] <= coef_value;
        end
    end

    // Tap sequencing
    logic [KCNT_W-1:0] k_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [HA_W-1:0]   ptr_reg;
    logic              tap_gate;

    assign tap_gate = (CMP_W'(k_reg) < CMP_W'(fill_reg)) && (idx_reg < IDX_W'(COEF_DEPTH));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            k_reg   <= '0;
            idx_reg <= IDX_W'(res_reg);
            ptr_reg <= head_reg;
        end else if (cmd.issue) begin
            k_reg   <= k_reg + KCNT_W'(1);
            idx_reg <= idx_reg + IDX_W'(up_reg);
            ptr_reg <= (ptr_reg == '0) ? HA_W'(FILTER_TAPS - 1) : ptr_reg - HA_W'(1);
        end
    end

    // MAC pipeline: read, multiply, accumulate
    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic signed [COEF_W-1:0]   coef_rd_reg;
    logic                       coef_ok_reg;
    logic                       gate_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            hist_rd_reg <= hist_mem[ptr_reg];
            coef_rd_reg <= coef_mem[idx_reg[CA_W-1:0]];
            coef_ok_reg <= coef_vld_reg[idx_reg[CA_W-1:0]];
            gate_reg    <= tap_gate;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            if (gate_reg && coef_ok_reg) begin
                prod_reg <= hist_rd_reg * coef_rd_reg;
            end else begin
                prod_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up, then saturate to Q1.15
    logic signed [ACC_W:0]      rnd_sum;
    logic signed [ACC_W-16:0]   rnd_q;
    logic signed [SAMPLE_W-1:0] rnd_sat;
    logic signed [SAMPLE_W-1:0] rnd_reg;

    assign rnd_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(32768);
    assign rnd_q   = rnd_sum[ACC_W:16];

    always_comb begin
        if (rnd_q > (ACC_W - 15)'(32767)) begin
            rnd_sat = 16'sh7fff;
        end else if (rnd_q < -(ACC_W - 15)'(32768)) begin
            rnd_sat = 16'sh8000;
        end else begin
            rnd_sat = rnd_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            rnd_reg <= rnd_sat;
        end
    end

    // Output register
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_data_reg;
    logic                       m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_pass) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= rnd_reg;
            m_last_reg <= last_phase;
        end else if (cmd.emit_pass) begin
            m_data_reg <= pass_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        status.in_push    = s_axis_tuser == ACT_PUSH;
        status.pass_mode  = pass_mode;
        status.has_output = has_output;
        status.tap_last   = TAPS_W'(k_reg) == (taps_reg - TAPS_W'(1));
        status.pipe_empty = !v1_reg && !v2_reg;
        status.last_phase = last_phase;
        status.out_free   = !m_valid_reg || m_axis_tready;
    end

endmodule

[rtl/core/polyphase_rational_resampler_top.sv]
// Top level of the streaming L/M polyphase FIR resampler.
//
// Input stream (s_axis_*): tuser selects the kind of item - push a sample, write one
// prototype tap into the coefficient store, or clear the history line and phase residue.
// Output stream (m_axis_*): one transfer per resampled sample; tlast marks the last
// result caused by a push. A push causes zero to L results; the other kinds cause none.
// Configuration (cfg_*): index 0 sets L, 1 sets M, 2 sets taps per branch; write only
// while the block is idle. cfg_ready is always high.
// Sequence: a push with L = M = 1 passes the sample straight through. Otherwise each
// result takes these steps: set up the branch, one multiply-accumulate per tap through a
// single 16x18 multiplier, pipeline drain, round, and load the output register. A
// coefficient write or clear leaves the block idle, ready for the next item.
// Reset (aresetn, synchronous, active low): L = M = taps = 1, residue and history
// cleared, coefficient store reads as zero at once - no sweep.
// Stalls: one output register holds a finished result; while the receiver stalls the
// next result is computed and then held until the register frees. Once the last
// result of a push sits in the output register a new item is taken.
module polyphase_rational_resampler_top #(
    parameter int FILTER_TAPS = rpr_pkg::DEF_FILTER_TAPS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] sample_in, [23:16] coef_index, [41:24] coef_value, [47:42] zero
    input  logic [rpr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [rpr_pkg::ACTION_W-1:0]   s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] sample_out
    output logic [rpr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);
    import rpr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Settings are plain registers: accept every write at once
    assign cfg_ready = 1'b1;

    rpr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    rpr_datapath #(
        .FILTER_TAPS (FILTER_TAPS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

[rtl/core/rpr_checker.sv]
// Port-level assertions for the resampler top level, with its bind.
module rpr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [rpr_pkg::ACTION_W-1:0]  s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import rpr_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // An item that is no push never produces a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_PUSH) && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result after non-push item");

    // An item that is no push leaves the input ready in the next cycle
    a_nonpush_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_PUSH) |=> s_axis_tready)
        else $error("non-push item held the input");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind polyphase_rational_resampler_top rpr_checker u_rpr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
